[rtl/btpc_pkg.sv]
// Shared types and constants for the barometric compensation block.
// No dependencies.
package btpc_pkg;

   localparam int RAW_W   = 20;
   localparam int TEMP_W  = 16;
   localparam int PRESS_W = 25;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_IDX_W-1:0] REG_TEMP_CAL  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_P1  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_P5  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PRESS_P9  = 8'd3;

   typedef struct packed {
      logic [15:0] t1;
      logic [15:0] t2;
      logic [15:0] t3;
      logic [15:0] p1;
      logic [15:0] p2;
      logic [15:0] p3;
      logic [15:0] p4;
      logic [15:0] p5;
      logic [15:0] p6;
      logic [15:0] p7;
      logic [15:0] p8;
      logic [15:0] p9;
   } cal_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temperature;
   } sample_type;

endpackage

[rtl/btpc_front.sv]
// Input side: takes raw sample pairs and queues them for the compute engine.
// Depends on btpc_pkg.
module btpc_front import btpc_pkg::*; #(
   parameter int Depth = QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  sample_type push_data,
   output logic       full,
   output logic       head_valid,
   output sample_type head_data,
   input  logic       pop
);
   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;

   sample_type            mem_ff [Depth];
   logic [PTR_W-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]        cnt_ff, cnt_in;
   logic                  do_push, do_pop;

   assign full       = (cnt_ff == (PTR_W+1)'(Depth));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(Depth-1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(Depth-1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

[rtl/btpc_mul.sv]
// 64x64 multiplier, low 64 bits of the product, one 32x32 partial per cycle.
// Depends on btpc_pkg.
module btpc_mul import btpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op_a,
   input  logic [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);
   logic [63:0] a_ff, b_ff, acc_ff, acc_in;
   logic [1:0]  ph_ff, ph_in;
   logic        run_ff, run_in, done_ff, done_in;
   logic [31:0] x, y;
   logic [63:0] part;

   always_comb begin
      unique case (ph_ff)
         2'd0:    begin x = a_ff[31:0];  y = b_ff[31:0];  end
         2'd1:    begin x = a_ff[63:32]; y = b_ff[31:0];  end
         default: begin x = a_ff[31:0];  y = b_ff[63:32]; end
      endcase
      part = 64'(x) * 64'(y);
   end

   always_comb begin
      acc_in  = acc_ff;
      ph_in   = ph_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         ph_in  = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         acc_in = (ph_ff == 2'd0) ? part : acc_ff + {part[31:0], 32'd0};
         ph_in  = ph_ff + 2'd1;
         if (ph_ff == 2'd2) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         ph_ff   <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         ph_ff   <= ph_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule

[rtl/btpc_div.sv]
// Signed Q16 divider, one quotient bit per cycle, clamped to magnitude 2^38.
// Depends on btpc_pkg.
module btpc_div import btpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [63:0] den,
   output logic        done,
   output logic [63:0] quo
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_CHK  = 3'd1;
   localparam logic [2:0] S_QA   = 3'd2;
   localparam logic [2:0] S_QB   = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;
   localparam logic [63:0] LIMIT = 64'd1 << 38;

   logic [2:0]  st_ff, st_in;
   logic [63:0] rem_ff, rem_in, ud_ff, quo_ff, quo_in;
   logic [85:0] dsh_ff, dsh_in;
   logic [37:0] q_ff, q_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        neg_ff, sat_ff, sat_in, done_ff, done_in;
   logic        fit;
   logic [63:0] mag;

   assign fit = ({22'd0, rem_ff} >= dsh_ff);
   assign mag = sat_ff ? LIMIT : {26'd0, q_ff};

   always_comb begin
      st_in   = st_ff;
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      sat_in  = sat_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (start) begin
               st_in = S_CHK;
            end
         end
         S_CHK: begin
            // quotient of 2^22 or more saturates
            sat_in = ({22'd0, rem_ff} >= {ud_ff, 22'd0});
            dsh_in = {1'b0, ud_ff, 21'd0};
            cnt_in = 5'd21;
            q_in   = '0;
            st_in  = ({22'd0, rem_ff} >= {ud_ff, 22'd0}) ? S_FIN : S_QA;
         end
         S_QA, S_QB: begin
            q_in   = {q_ff[36:0], fit};
            rem_in = fit ? rem_ff - dsh_ff[63:0] : rem_ff;
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               if (st_ff == S_QA) begin
                  rem_in = {rem_in[47:0], 16'd0};
                  dsh_in = {7'd0, ud_ff, 15'd0};
                  cnt_in = 5'd15;
                  st_in  = S_QB;
               end else begin
                  st_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            quo_in  = neg_ff ? 64'd0 - mag : mag;
            done_in = 1'b1;
            st_in   = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      sat_ff <= sat_in;
      quo_ff <= quo_in;
      if (start && st_ff == S_IDLE) begin
         neg_ff <= num[63] ^ den[63];
         rem_ff <= num[63] ? 64'd0 - num : num;
         ud_ff  <= den[63] ? 64'd0 - den : den;
      end else begin
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;
endmodule

[rtl/btpc_back.sv]
// Compute engine: sequences the calibration formulas over the shared
// multiplier and divider. Depends on btpc_pkg, btpc_mul, btpc_div.
module btpc_back import btpc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cal_type             cal,
   input  logic                head_valid,
   input  sample_type          head_data,
   output logic                pop,
   output logic                rsp_valid,
   output logic [TEMP_W-1:0]   rsp_temp_centideg,
   output logic [PRESS_W-1:0]  rsp_press_q8_pa,
   output logic                rsp_divide_error
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TF1  = 4'd1;
   localparam logic [3:0] S_DD   = 4'd2;
   localparam logic [3:0] S_TF3  = 4'd3;
   localparam logic [3:0] S_S    = 4'd4;
   localparam logic [3:0] S_W1   = 4'd5;
   localparam logic [3:0] S_W2   = 4'd6;
   localparam logic [3:0] S_U1   = 4'd7;
   localparam logic [3:0] S_U2   = 4'd8;
   localparam logic [3:0] S_DEN  = 4'd9;
   localparam logic [3:0] S_NUM  = 4'd10;
   localparam logic [3:0] S_DIV  = 4'd11;
   localparam logic [3:0] S_G    = 4'd12;
   localparam logic [3:0] S_S9   = 4'd13;
   localparam logic [3:0] S_P8   = 4'd14;

   logic [3:0]  st_ff, st_in;
   logic        issued_ff, issued_in;
   logic [RAW_W-1:0] a_ff, b_ff;
   logic signed [63:0] x_ff, x_in, y_ff, y_in, tf_ff, tf_in, v_ff, v_in;
   logic signed [63:0] s_ff, s_in, w_ff, w_in, p_ff, p_in;
   logic [TEMP_W-1:0]  temp_ff, temp_in;
   logic               rv_ff, rv_in, err_ff, err_in;
   logic [PRESS_W-1:0] pr_ff, pr_in;

   logic               mul_start, mul_done, div_start, div_done;
   logic signed [63:0] op_a, op_b, m, quo;
   logic signed [63:0] t1c, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
   logic signed [63:0] t1v, dv, tf5, tcv, vs, ps, den, num0, sum, prv;

   always_comb begin
      t1c = {48'd0, cal.t1};
      p1  = {48'd0, cal.p1};
      t2  = 64'(signed'(cal.t2));
      t3  = 64'(signed'(cal.t3));
      p2  = 64'(signed'(cal.p2));
      p3  = 64'(signed'(cal.p3));
      p4  = 64'(signed'(cal.p4));
      p5  = 64'(signed'(cal.p5));
      p6  = 64'(signed'(cal.p6));
      p7  = 64'(signed'(cal.p7));
      p8  = 64'(signed'(cal.p8));
      p9  = 64'(signed'(cal.p9));
      t1v = ({44'd0, a_ff} <<< 2) - (t1c <<< 6);
      dv  = {44'd0, a_ff} - (t1c <<< 4);
      vs  = v_ff >>> 8;
      ps  = p_ff >>> 8;
      tf5 = (tf_ff <<< 2) + tf_ff + (64'sd1 <<< 23);
      tcv = tf5 >>> 24;
      den = m >>> 15;
      num0 = (64'sd1048576 - $signed({44'd0, b_ff})) * 64'sd65536 - (w_ff >>> 12);
      sum = y_ff + (m >>> 15) + (p7 <<< 16);
      prv = (p_ff + (sum >>> 4) + 64'sd128) >>> 8;
   end

   always_comb begin
      unique case (st_ff)
         S_TF1:   begin op_a = t1v;           op_b = t2;        end
         S_DD:    begin op_a = dv;            op_b = dv;        end
         S_TF3:   begin op_a = y_ff;          op_b = t3;        end
         S_S:     begin op_a = vs;            op_b = vs;        end
         S_W1:    begin op_a = s_ff >>> 15;   op_b = p6;        end
         S_W2:    begin op_a = v_ff;          op_b = p5;        end
         S_U1:    begin op_a = s_ff >>> 19;   op_b = p3;        end
         S_U2:    begin op_a = v_ff;          op_b = p2;        end
         S_DEN:   begin op_a = x_ff + (64'sd1 <<< 31); op_b = p1; end
         S_NUM:   begin op_a = x_ff;          op_b = 64'sd6250; end
         S_G:     begin op_a = ps;            op_b = ps;        end
         S_S9:    begin op_a = x_ff >>> 16;   op_b = p9;        end
         S_P8:    begin op_a = p_ff;          op_b = p8;        end
         default: begin op_a = '0;            op_b = '0;        end
      endcase
   end

   assign mul_start = !issued_ff && st_ff != S_IDLE && st_ff != S_DIV;
   assign pop       = (st_ff == S_IDLE) && head_valid;

   always_comb begin
      st_in     = st_ff;
      issued_in = issued_ff;
      x_in = x_ff;  y_in = y_ff;  tf_in = tf_ff;  v_in = v_ff;
      s_in = s_ff;  w_in = w_ff;  p_in = p_ff;
      temp_in = temp_ff;
      rv_in = 1'b0;  err_in = err_ff;  pr_in = pr_ff;
      div_start = 1'b0;
      if (mul_start) begin
         issued_in = 1'b1;
      end
      if (st_ff == S_IDLE) begin
         if (head_valid) begin
            st_in = S_TF1;
         end
      end else if (st_ff == S_DIV) begin
         if (div_done) begin
            p_in  = quo;
            st_in = S_G;
         end
      end else if (mul_done) begin
         issued_in = 1'b0;
         st_in     = st_ff + 4'd1;
         unique case (st_ff)
            S_TF1: x_in = m;
            S_DD:  y_in = m;
            S_TF3: begin
               tf_in = x_ff + (m >>> 18);
               v_in  = ((x_ff + (m >>> 18)) >>> 1) - 64'sd4194304000;
            end
            S_S: begin
               s_in = m;
               if (tcv > 64'sd32767) begin
                  temp_in = 16'h7FFF;
               end else if (tcv < -64'sd32768) begin
                  temp_in = 16'h8000;
               end else begin
                  temp_in = tcv[15:0];
               end
            end
            S_W1:  x_in = m;
            S_W2:  w_in = ((x_ff + (m <<< 1)) >>> 2) + (p4 <<< 32);
            S_U1:  x_in = m;
            S_U2:  x_in = (x_ff + m) >>> 19;
            S_DEN: begin
               if (den == 64'sd0) begin
                  rv_in  = 1'b1;
                  err_in = 1'b1;
                  pr_in  = '0;
                  st_in  = S_IDLE;
               end else begin
                  y_in = den;
                  x_in = num0;
               end
            end
            S_NUM: div_start = 1'b1;
            S_G:   x_in = m;
            S_S9:  y_in = m >>> 15;
            S_P8: begin
               rv_in  = 1'b1;
               err_in = 1'b0;
               st_in  = S_IDLE;
               if (prv < 64'sd0) begin
                  pr_in = '0;
               end else if (prv > 64'sd33554431) begin
                  pr_in = '1;
               end else begin
                  pr_in = prv[PRESS_W-1:0];
               end
            end
            default: st_in = S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         issued_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         st_ff     <= st_in;
         issued_ff <= issued_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;  y_ff <= y_in;  tf_ff <= tf_in;  v_ff <= v_in;
      s_ff <= s_in;  w_ff <= w_in;  p_ff <= p_in;
      temp_ff <= temp_in;  err_ff <= err_in;  pr_ff <= pr_in;
      if (pop) begin
         a_ff <= head_data.raw_temperature;
         b_ff <= head_data.raw_pressure;
      end
   end

   btpc_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (op_a),
      .op_b    (op_b),
      .done    (mul_done),
      .product (m)
   );

   btpc_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (m),
      .den   (y_ff),
      .done  (div_done),
      .quo   (quo)
   );

   assign rsp_valid         = rv_ff;
   assign rsp_temp_centideg = temp_ff;
   assign rsp_press_q8_pa   = pr_ff;
   assign rsp_divide_error  = err_ff;
endmodule

[rtl/baro_temp_press_compensation.sv]
// Barometric compensation: each sample makes up to 13 passes through the shared
// multiplier and, unless the pressure divisor is zero, one divide. A two-entry
// queue takes new samples while one is in work. rsp_valid pulses one cycle; the
// receiver cannot stall. Synchronous reset clears the queue, the engine and all
// calibration registers to zero.
module baro_temp_press_compensation import btpc_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [RAW_W-1:0]     req_raw_pressure,
   input  logic [RAW_W-1:0]     req_raw_temperature,
   output logic                 rsp_valid,
   output logic [TEMP_W-1:0]    rsp_temp_centideg,
   output logic [PRESS_W-1:0]   rsp_press_q8_pa,
   output logic                 rsp_divide_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);
   logic [47:0] tcal_ff;
   logic [63:0] pcal1_ff, pcal2_ff;
   logic [15:0] pcal3_ff;
   cal_type     cal;
   sample_type  push_data, head_data;
   logic        full, head_valid, pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tcal_ff  <= '0;
         pcal1_ff <= '0;
         pcal2_ff <= '0;
         pcal3_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TEMP_CAL: tcal_ff  <= csr_wdata[47:0];
            REG_PRESS_P1: pcal1_ff <= csr_wdata;
            REG_PRESS_P5: pcal2_ff <= csr_wdata;
            REG_PRESS_P9: pcal3_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cal.t1 = tcal_ff[15:0];
      cal.t2 = tcal_ff[31:16];
      cal.t3 = tcal_ff[47:32];
      cal.p1 = pcal1_ff[15:0];
      cal.p2 = pcal1_ff[31:16];
      cal.p3 = pcal1_ff[47:32];
      cal.p4 = pcal1_ff[63:48];
      cal.p5 = pcal2_ff[15:0];
      cal.p6 = pcal2_ff[31:16];
      cal.p7 = pcal2_ff[47:32];
      cal.p8 = pcal2_ff[63:48];
      cal.p9 = pcal3_ff;
   end

   assign push_data = {req_raw_pressure, req_raw_temperature};
   assign busy = full;

   btpc_front #(.Depth(QueueDepth)) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (start),
      .push_data  (push_data),
      .full       (full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   btpc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cal               (cal),
      .head_valid        (head_valid),
      .head_data         (head_data),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_temp_centideg (rsp_temp_centideg),
      .rsp_press_q8_pa   (rsp_press_q8_pa),
      .rsp_divide_error  (rsp_divide_error)
   );
endmodule

[tb/testbench.sv]
// Self-checking bench for the barometric compensation block: drives raw
// samples and calibration writes, predicts every result with a Q16 model.
// Depends on btpc_pkg and baro_temp_press_compensation.
module testbench;
   import btpc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 8'd4;
   localparam int SETTLE_CYCLES = 130;
   localparam int STALL_LIMIT   = 4000;

   typedef struct packed {
      logic [TEMP_W-1:0]  temp;
      logic [PRESS_W-1:0] press;
      logic               div_err;
   } reading_type;

   class compensation_board;
      logic [47:0] temp_cal;
      logic [63:0] press_first;
      logic [63:0] press_second;
      logic [15:0] press_last;
      reading_type readings_due[$];
      int          errors;

      function new();
         temp_cal = '0;
         press_first = '0;
         press_second = '0;
         press_last = '0;
         errors = 0;
      endfunction

      task report(input string msg);
         $display("mismatch @%0t: %s", $time, msg);
         errors++;
      endtask

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
         case (idx)
            REG_TEMP_CAL: temp_cal = data[47:0];
            REG_PRESS_P1: press_first = data;
            REG_PRESS_P5: press_second = data;
            REG_PRESS_P9: press_last = data[15:0];
            default: ;
         endcase
      endfunction

      function longint sword(logic [15:0] x);
         return longint'($signed(x));
      endfunction

      function longint uword(logic [15:0] x);
         return longint'({48'd0, x});
      endfunction

      // Q16 quotient, truncated toward zero, clamped to 2^38
      function longint press_quotient(longint n, longint d);
         bit neg;
         longint unsigned un, ud, q, r, mag, lim;
         lim = 64'd1 << 38;
         neg = (n < 0) != (d < 0);
         un = (n < 0) ? 64'd0 - n : n;
         ud = (d < 0) ? 64'd0 - d : d;
         q = un / ud;
         r = un % ud;
         if (q >= (64'd1 << 22)) mag = lim;
         else begin
            mag = (q << 16) + (r << 16) / ud;
            if (mag > lim) mag = lim;
         end
         return neg ? -longint'(mag) : longint'(mag);
      endfunction

      function void note_sample(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
         longint a, b, t1c, t2c, t3c, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         longint t1, dd, tf, tc, v, vs, s, w, u, den, num, p, ps, g, sum, pr;
         reading_type exp_r;
         b = longint'({44'd0, raw_p});
         a = longint'({44'd0, raw_t});
         t1c = uword(temp_cal[15:0]);
         t2c = sword(temp_cal[31:16]);
         t3c = sword(temp_cal[47:32]);
         p1 = uword(press_first[15:0]);
         p2 = sword(press_first[31:16]);
         p3 = sword(press_first[47:32]);
         p4 = sword(press_first[63:48]);
         p5 = sword(press_second[15:0]);
         p6 = sword(press_second[31:16]);
         p7 = sword(press_second[47:32]);
         p8 = sword(press_second[63:48]);
         p9 = sword(press_last);

         t1 = a * 4 - t1c * 64;
         dd = a - t1c * 16;
         tf = t1 * t2c + ((dd * dd * t3c) >>> 18);
         tc = (tf * 5 + 64'sd8388608) >>> 24;
         if (tc > 32767) tc = 32767;
         if (tc < -32768) tc = -32768;
         exp_r.temp = tc[15:0];

         v = (tf >>> 1) - 64'sd4194304000;
         vs = v >>> 8;
         s = vs * vs;
         w = (((s >>> 15) * p6 + 2 * v * p5) >>> 2) + p4 * 64'sd4294967296;
         u = ((s >>> 19) * p3 + v * p2) >>> 19;
         den = ((u + 64'sd2147483648) * p1) >>> 15;
         if (den == 0) begin
            exp_r.press = '0;
            exp_r.div_err = 1'b1;
         end else begin
            num = ((64'sd1048576 - b) * 65536 - (w >>> 12)) * 6250;
            p = press_quotient(num, den);
            ps = p >>> 8;
            g = ps * ps;
            sum = ((((g >>> 16) * p9) >>> 15) + ((p * p8) >>> 15)) + p7 * 65536;
            pr = (p + (sum >>> 4) + 128) >>> 8;
            if (pr < 0) pr = 0;
            if (pr > 33554431) pr = 33554431;
            exp_r.press = pr[PRESS_W-1:0];
            exp_r.div_err = 1'b0;
         end
         readings_due.push_back(exp_r);
      endfunction

      task check_reading(logic [TEMP_W-1:0] t, logic [PRESS_W-1:0] p, logic e);
         reading_type exp_r;
         if (readings_due.size() == 0) begin
            report($sformatf("unexpected result temp=%0d press=%0d err=%0b", t, p, e));
         end else begin
            exp_r = readings_due.pop_front();
            if (t !== exp_r.temp)
               report($sformatf("temp got %0d want %0d", $signed(t), $signed(exp_r.temp)));
            if (p !== exp_r.press)
               report($sformatf("press got %0d want %0d", p, exp_r.press));
            if (e !== exp_r.div_err)
               report($sformatf("divide_error got %0b want %0b", e, exp_r.div_err));
         end
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [RAW_W-1:0]     req_raw_pressure;
   logic [RAW_W-1:0]     req_raw_temperature;
   logic                 rsp_valid;
   logic [TEMP_W-1:0]    rsp_temp_centideg;
   logic [PRESS_W-1:0]   rsp_press_q8_pa;
   logic                 rsp_divide_error;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   compensation_board board;
   int stall_cycles;

   baro_temp_press_compensation u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_raw_pressure(req_raw_pressure), .req_raw_temperature(req_raw_temperature),
      .rsp_valid(rsp_valid), .rsp_temp_centideg(rsp_temp_centideg),
      .rsp_press_q8_pa(rsp_press_q8_pa), .rsp_divide_error(rsp_divide_error),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) board.note_sample(req_raw_pressure, req_raw_temperature);
         if (rsp_valid) board.check_reading(rsp_temp_centideg, rsp_press_q8_pa,
                                            rsp_divide_error);
      end
   end

   // watchdog: any transfer resets the count
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // start is left high after a transfer; this task lowers it only when a gap is drawn
   task send_sample(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_raw_pressure <= raw_p;
      req_raw_temperature <= raw_t;
      do @(posedge clock); while (busy);
   endtask

   task drain();
      start <= 1'b0;
      while (board.readings_due.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task load_cal(input logic [63:0] tc, input logic [63:0] pf,
                 input logic [63:0] ps, input logic [63:0] p9);
      drain();
      write_csr(REG_TEMP_CAL, tc);
      write_csr(REG_PRESS_P1, pf);
      write_csr(REG_PRESS_P5, ps);
      write_csr(REG_PRESS_P9, p9);
   endtask

   function logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task run_random(input int count);
      logic [RAW_W-1:0] rp, rt;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            rp = 20'(300000 + $urandom_range(0, 400000));
            rt = 20'(420000 + $urandom_range(0, 200000));
         end else begin
            rp = 20'($urandom());
            rt = 20'($urandom());
         end
         send_sample(rp, rt);
      end
   endtask

   // typical factory words packed per register layout
   localparam logic [63:0] TYP_TEMP = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
   localparam logic [63:0] TYP_PF   = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
   localparam logic [63:0] TYP_PS   = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
   localparam logic [63:0] TYP_P9   = 64'd6000;

   initial begin
      logic [63:0] tc, pf, ps;
      board = new();
      reset = 1'b1;
      start = 1'b0;
      req_raw_pressure = '0;
      req_raw_temperature = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all-zero calibration: divisor is zero, error flagged
      send_sample('0, '0);
      send_sample('1, '1);

      load_cal(TYP_TEMP, TYP_PF, TYP_PS, TYP_P9);
      send_sample('0, '0);
      send_sample('1, '1);
      send_sample('0, '1);
      send_sample('1, '0);
      send_sample(20'd415148, 20'd519888);
      send_sample(20'd415148, 20'd519888);
      // writes to unknown indexes are dropped
      drain();
      write_csr(REG_UNUSED, rand64());
      write_csr(8'hFF, rand64());
      send_sample(20'd300000, 20'd500000);

      // temperature saturates high, then low
      load_cal({16'd0, 16'h7FFF, 16'h7FFF, 16'd0}, TYP_PF, TYP_PS, TYP_P9);
      send_sample('1, '1);
      load_cal({16'd0, 16'h8000, 16'h8000, 16'd0}, TYP_PF, TYP_PS, TYP_P9);
      send_sample('1, '1);
      // P1 zero gives a zero divisor, temperature still valid
      load_cal(TYP_TEMP, {TYP_PF[63:16], 16'd0}, TYP_PS, TYP_P9);
      send_sample(20'd415148, 20'd519888);
      // all ones, extra bits beyond register widths
      load_cal('1, '1, '1, '1);
      send_sample('0, '0);
      send_sample('1, '1);
      load_cal(TYP_TEMP, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
               {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 64'h7FFF);
      send_sample('0, '0);
      send_sample('1, '1);
      load_cal(TYP_TEMP, {16'h8000, 16'h8000, 16'h8000, 16'd1},
               {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 64'h8000);
      send_sample('0, '0);
      send_sample('1, '1);

      load_cal(TYP_TEMP, TYP_PF, TYP_PS, TYP_P9);
      run_random(250);
      for (int ph = 0; ph < 10; ph++) begin
         if (ph % 2 == 0) begin
            // typical words with random low-order jitter
            tc = TYP_TEMP ^ {16'd0, 8'd0, 8'($urandom()), 8'd0, 8'($urandom()),
                             8'd0, 8'($urandom())};
            pf = TYP_PF ^ {8'd0, 8'($urandom()), 8'd0, 8'($urandom()),
                           8'd0, 8'($urandom()), 8'd0, 8'($urandom())};
            ps = TYP_PS ^ {8'd0, 8'($urandom()), 8'd0, 8'($urandom()),
                           8'd0, 8'($urandom()), 8'd0, 8'($urandom())};
            load_cal(tc, pf, ps, TYP_P9 ^ 64'($urandom_range(0, 255)));
         end else begin
            load_cal(rand64(), rand64(), rand64(), rand64());
         end
         run_random(110);
      end

      drain();
      while (board.readings_due.size() > 0) begin
         void'(board.readings_due.pop_front());
         board.report("result never arrived");
      end
      if (board.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
